### hdl/ckv_pkg.sv
// Package for the compacting key/value table: sizes, operation and status
// codes, sequencer states and the per-slot command struct.
// No dependencies.
`default_nettype none
package ckv_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int OP_W        = 2;
  localparam int ST_W        = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_MISS = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC
  } fsm_t;

  // per-slot command: compare, write new pair, take neighbor's pair
  typedef struct packed {
    logic cmp;
    logic wr;
    logic sh;
  } cell_cmd_t;

endpackage
`default_nettype wire

### hdl/ckv_cell.sv
// One slot of the table: key/value registers, a registered match flag and
// a load path from the next slot up for compaction. Uses ckv_pkg.
`default_nettype none
module ckv_cell
  import ckv_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cell_cmd_t        cmd,
  input  wire logic [KEY_W-1:0] op_key,
  input  wire logic [VAL_W-1:0] op_value,
  input  wire logic [KEY_W-1:0] nb_key,
  input  wire logic [VAL_W-1:0] nb_value,
  output logic      [KEY_W-1:0] key,
  output logic      [VAL_W-1:0] value,
  output logic                  empty,
  output logic                  match
);

  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic             match_r, match_nxt;

  // slot update: insert wins over shift (never both)
  always_comb begin
    key_nxt   = key_r;
    val_nxt   = val_r;
    match_nxt = match_r;
    if (cmd.wr) begin
      key_nxt = op_key;
      val_nxt = op_value;
    end else if (cmd.sh) begin
      key_nxt = nb_key;
      val_nxt = nb_value;
    end
    // an empty slot never matches
    if (cmd.cmp) begin
      match_nxt = (key_r != '0) && (key_r == op_key);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      val_r   <= '0;
      match_r <= 1'b0;
    end else begin
      key_r   <= key_nxt;
      val_r   <= val_nxt;
      match_r <= match_nxt;
    end
  end

  assign key   = key_r;
  assign value = val_r;
  assign empty = (key_r == '0);
  assign match = match_r;

endmodule
`default_nettype wire

### hdl/compacting_key_value_table_unit.sv
// Top level of the compacting key/value table: item register, sequencer,
// a chain of ckv_cell slots and the result register. Uses ckv_pkg, ckv_cell.
//
// Usage:
//   Input channel in_valid/in_stall carries one operation beat (insert,
//   lookup or delete) with a key and a value. Result channel
//   out_valid/out_stall carries one beat per input: found value and status.
//   Each beat passes through the accept edge, an edge where every slot
//   registers its key compare in parallel, and an edge where the first
//   match is resolved through a log-depth prefix OR over the slot flags and
//   the table is updated (insert into the first empty slot, or every slot
//   from the hit upward takes its upper neighbor's pair). The result is
//   valid on the cycle after that. One beat is in flight at a time: a new
//   beat is not accepted until the last one has passed its update step.
//   in_stall is high while a beat is in flight. The result register frees
//   the core: a new beat is accepted while a result still waits. If the
//   receiver stalls with a result waiting, the next beat holds before its
//   update step until the result is taken.
//   Synchronous reset empties every slot and drops any pending beat;
//   in_stall stays high while reset is held.
`default_nettype none
module compacting_key_value_table_unit
  import ckv_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [OP_W-1:0]  in_operation,
  input  wire logic [KEY_W-1:0] in_key,
  input  wire logic [VAL_W-1:0] in_value,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [VAL_W-1:0] out_found_value,
  output logic      [ST_W-1:0]  out_status
);

  fsm_t state_r, state_nxt;

  logic [OP_W-1:0]  op_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;

  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_fv_r, out_fv_nxt;
  logic [ST_W-1:0]  out_st_r, out_st_nxt;

  logic [KEY_W-1:0] cell_key [TABLE_DEPTH];
  logic [VAL_W-1:0] cell_val [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] cell_empty;
  logic [TABLE_DEPTH-1:0] cell_match;
  cell_cmd_t        cell_cmd [TABLE_DEPTH];

  logic [TABLE_DEPTH-1:0] pfx;
  logic [TABLE_DEPTH-1:0] first_hit;
  logic [TABLE_DEPTH-1:0] ins_slot;
  logic [VAL_W-1:0]       hit_value;
  logic                   hit;
  logic                   full;
  logic                   accept;
  logic                   exec_go;

  assign accept  = in_valid && !in_stall;
  assign exec_go = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  // item register
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_operation;
      key_r <= in_key;
      val_r <= in_value;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = !rst_n;
        if (in_valid) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (exec_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // prefix OR of match flags: slot i is at or above the first hit
  always_comb begin
    pfx = cell_match;
    for (int l = 0; l < IDX_W; l++) begin
      pfx = pfx | (pfx << (1 << l));
    end
    first_hit = cell_match & ~(pfx << 1);
    hit       = |cell_match;
  end

  // value of the first hit
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_value = hit_value | (cell_val[i] & {VAL_W{first_hit[i]}});
    end
  end

  // table is packed: the first empty slot sits just above the last full one
  always_comb begin
    ins_slot[0] = cell_empty[0];
    for (int i = 1; i < TABLE_DEPTH; i++) begin
      ins_slot[i] = cell_empty[i] && !cell_empty[i-1];
    end
    full = !cell_empty[TABLE_DEPTH-1];
  end

  // slot commands
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      cell_cmd[i].cmp = (state_r == S_CMP);
      cell_cmd[i].wr  = exec_go && (op_r == OP_INSERT) && (key_r != '0) && ins_slot[i];
      cell_cmd[i].sh  = exec_go && (op_r == OP_DELETE) && pfx[i];
    end
  end

  // chain of slots; the top slot takes zeros on compaction
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic [KEY_W-1:0] nb_key;
    logic [VAL_W-1:0] nb_val;
    if (g == TABLE_DEPTH - 1) begin : g_top
      assign nb_key = '0;
      assign nb_val = '0;
    end else begin : g_mid
      assign nb_key = cell_key[g+1];
      assign nb_val = cell_val[g+1];
    end
    ckv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cell_cmd[g]),
      .op_key   (key_r),
      .op_value (val_r),
      .nb_key   (nb_key),
      .nb_value (nb_val),
      .key      (cell_key[g]),
      .value    (cell_val[g]),
      .empty    (cell_empty[g]),
      .match    (cell_match[g])
    );
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_fv_nxt    = out_fv_r;
    out_st_nxt    = out_st_r;
    if (exec_go) begin
      out_valid_nxt = 1'b1;
      out_fv_nxt    = '0;
      out_st_nxt    = ST_OK;
      case (op_r)
        OP_INSERT: begin
          if ((key_r != '0) && full) begin
            out_st_nxt = ST_FULL;
          end
        end
        OP_LOOKUP, OP_DELETE: begin
          if (hit) begin
            out_fv_nxt = hit_value;
          end else begin
            out_st_nxt = ST_MISS;
          end
        end
        default: begin
          out_st_nxt = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_fv_r <= out_fv_nxt;
    out_st_r <= out_st_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found_value = out_fv_r;
  assign out_status      = out_st_r;

endmodule
`default_nettype wire

### hdl/ckv_checker.sv
// Port-level checks for compacting_key_value_table_unit, bound to the top.
// Uses ckv_pkg.
`default_nettype none
module ckv_checker
  import ckv_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic [OP_W-1:0]  in_operation,
  input wire logic [KEY_W-1:0] in_key,
  input wire logic [VAL_W-1:0] in_value,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [VAL_W-1:0] out_found_value,
  input wire logic [ST_W-1:0]  out_status
);

  // one beat in flight: an accepted beat blocks the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a beat was in flight");

  // a stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_operation)
                                && $stable(in_key) && $stable(in_value)))
    else $error("stalled input beat changed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_found_value)
                                  && $stable(out_status)))
    else $error("stalled result changed");

  // full and miss never carry a value
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL || out_status == ST_MISS))
      |-> (out_found_value == '0))
    else $error("failed beat carries a value");

  // with no result waiting, no result appears before the accepted beat's update step
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_valid) |=> !out_valid ##1 !out_valid)
    else $error("result appeared too early");

endmodule

bind compacting_key_value_table_unit ckv_checker u_ckv_checker (.*);
`default_nettype wire
